>>> rtl/core/cdq_pkg.sv
// Shared constants, codes and types for the circular deque core.
package cdq_pkg;

  // Geometry
  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Request codes
  localparam logic [1:0] FUNC_PUSH_REAR  = 2'd0;
  localparam logic [1:0] FUNC_PUSH_FRONT = 2'd1;
  localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [1:0] FUNC_POP_REAR   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic       en;    // request accepted and not refused
    logic [1:0] func;  // request code
  } cdq_ctrl_t;

  typedef logic [DATA_WIDTH-1:0] cdq_data_t;

endpackage

>>> rtl/core/cdq_cell.sv
// One storage cell of the deque row; cell 0 is the front of the queue.
module cdq_cell (
  input  logic              clk,
  input  logic              rst,
  input  cdq_pkg::cdq_ctrl_t ctrl,
  input  cdq_pkg::cdq_data_t push_value,
  input  cdq_pkg::cdq_data_t left_data,
  input  logic              left_occ,
  input  cdq_pkg::cdq_data_t right_data,
  input  logic              right_occ,
  output cdq_pkg::cdq_data_t data,
  output logic              occ,
  output cdq_pkg::cdq_data_t rear_tap
);
  import cdq_pkg::*;

  logic is_rear;

  // This cell holds the rear entry when it is occupied and its right neighbour is not
  assign is_rear  = occ && !right_occ;
  assign rear_tap = is_rear ? data : '0;

  // Occupancy flag: control state, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.en) begin
      case (ctrl.func)
        FUNC_PUSH_FRONT: occ <= left_occ;
        FUNC_PUSH_REAR:  if (!occ && left_occ) occ <= 1'b1;
        FUNC_POP_FRONT:  occ <= right_occ;
        FUNC_POP_REAR:   if (is_rear) occ <= 1'b0;
        default:         occ <= occ;
      endcase
    end
  end

  // Payload: shifts with the row on front transfers, loads at the rear on push
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.func)
        FUNC_PUSH_FRONT: data <= left_data;
        FUNC_PUSH_REAR:  if (!occ && left_occ) data <= push_value;
        FUNC_POP_FRONT:  data <= right_data;
        default:         data <= data;
      endcase
    end
  end

endmodule

>>> rtl/core/circular_deque_core.sv
// Double-ended queue built as a row of shifting storage cells.
// Result: registered in the output register in the cycle after its input transfer.
// Throughput: one request per cycle while results are taken; the single output
//   register holds off new input only while a result waits under stall.
// Reset: synchronous, active high; queue emptied, no result pending.
// Every cell updates in the same cycle, so pops and pushes at either end cost the same.
module circular_deque_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic signed [31:0]        push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        pop_value,
  output logic [1:0]                status,
  output logic                      is_full,
  output logic                      is_empty,
  output logic [3:0]                occupancy
);
  import cdq_pkg::*;

  cdq_ctrl_t         ctrl;
  cdq_data_t         cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_occ;
  cdq_data_t         cell_tap  [DEPTH];
  cdq_data_t         push_data;
  cdq_data_t         rear_value;

  logic              in_fire;
  logic              is_push;
  logic              full;
  logic              empty;
  logic              refused;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [31:0]       pop_next;
  logic [1:0]        status_next;

  assign push_data = cdq_data_t'(push_value);

  // Input handshake
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Request decode and refusal
  assign is_push = (func == FUNC_PUSH_REAR) || (func == FUNC_PUSH_FRONT);
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign refused = is_push ? full : empty;

  assign ctrl.en   = in_fire && !refused;
  assign ctrl.func = func;

  // Row of cells; cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdq_data_t l_data, r_data;
    logic      l_occ, r_occ;

    if (i == 0) begin : g_first
      assign l_data = push_data;
      assign l_occ  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[i+1];
      assign r_occ  = cell_occ[i+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .push_value (push_data),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (cell_data[i]),
      .occ        (cell_occ[i]),
      .rear_tap   (cell_tap[i])
    );
  end

  // Rear entry: at most one cell taps out (exactly one unless empty), the rest give zero
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_value = rear_value | cell_tap[i];
    end
  end

  // Result value, status and new count
  always_comb begin
    pop_next    = '0;
    status_next = ST_OK;
    count_next  = count;
    if (is_push) begin
      if (full) status_next = ST_OVERFLOW;
      else      count_next  = count + CNT_W'(1);
    end else if (empty) begin
      status_next = ST_UNDERFLOW;
      pop_next    = '1;
    end else begin
      count_next = count - CNT_W'(1);
      if (func == FUNC_POP_FRONT) pop_next = 32'(signed'(cell_data[0]));
      else                        pop_next = 32'(signed'(rear_value));
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pop_value <= pop_next;
      status    <= status_next;
      is_full   <= (count_next == CNT_W'(DEPTH));
      is_empty  <= (count_next == '0);
      occupancy <= 4'(count_next);
    end
  end

endmodule

>>> tb/circular_deque_checker.sv
// Scoreboard for the circular deque core: predicts each result and compares it.
`timescale 1ns / 1ps

module circular_deque_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] push_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pop_value,
  input  logic [1:0]         status,
  input  logic               is_full,
  input  logic               is_empty,
  input  logic [3:0]         occupancy,
  output int                 mismatches,
  output int                 pending
);
  import cdq_pkg::*;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic               is_full;
    logic               is_empty;
    logic [3:0]         occupancy;
  } deque_result_t;

  // Shadow contents, front of the deque at index 0
  cdq_data_t     shadow_deque[$];
  deque_result_t awaited_results[$];
  int            fail_total = 0;
  int            awaited_total = 0;

  assign mismatches = fail_total;
  assign pending    = awaited_total;

  // Apply one request to the shadow deque and return the result it should give
  function automatic deque_result_t apply_deque_op(logic [1:0] op, cdq_data_t value);
    deque_result_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      FUNC_PUSH_REAR, FUNC_PUSH_FRONT: begin
        if (shadow_deque.size() >= DEPTH)
          r.status = ST_OVERFLOW;
        else if (op == FUNC_PUSH_REAR)
          shadow_deque.push_back(value);
        else
          shadow_deque.push_front(value);
      end
      default: begin
        if (shadow_deque.size() == 0) begin
          r.status    = ST_UNDERFLOW;
          r.pop_value = -32'sd1;
        end else if (op == FUNC_POP_FRONT) begin
          r.pop_value = shadow_deque.pop_front();
        end else begin
          r.pop_value = shadow_deque.pop_back();
        end
      end
    endcase
    r.occupancy = 4'(shadow_deque.size());
    r.is_full   = (shadow_deque.size() == DEPTH);
    r.is_empty  = (shadow_deque.size() == 0);
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      fail_total++;
    end
  endtask

  // Result side first: a result never belongs to a request taken on the same edge
  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      shadow_deque.delete();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_total++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("pop_value", want.pop_value, pop_value);
          compare_field("status",    32'(want.status),    32'(status));
          compare_field("is_full",   32'(want.is_full),   32'(is_full));
          compare_field("is_empty",  32'(want.is_empty),  32'(is_empty));
          compare_field("occupancy", 32'(want.occupancy), 32'(occupancy));
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_deque_op(func, push_value));
    end
    awaited_total = awaited_results.size();
  end

endmodule

>>> tb/tb_circular_deque_core.sv
// Testbench top for the circular deque core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_circular_deque_core;
  import cdq_pkg::*;

  localparam int RANDOM_REQUESTS = 1525;
  localparam int IDLE_LIMIT      = 1000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = FUNC_PUSH_REAR;
  logic signed [31:0] push_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pop_value;
  logic [1:0]         status;
  logic               is_full;
  logic               is_empty;
  logic [3:0]         occupancy;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  circular_deque_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .push_value(push_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .pop_value(pop_value), .status(status),
    .is_full(is_full), .is_empty(is_empty), .occupancy(occupancy)
  );

  circular_deque_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .push_value(push_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .pop_value(pop_value), .status(status),
    .is_full(is_full), .is_empty(is_empty), .occupancy(occupancy),
    .mismatches(mismatches), .pending(pending)
  );

  // Receiver back-pressure, switched off during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL circular_deque_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request transfer, with an occasional gap in front of it
  task automatic send_request(input logic [1:0] op, input logic signed [31:0] value);
    int gap;
    if (!calm && $urandom_range(0, 99) < 3) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= op;
    push_value <= value;
    // in_stall is settled by the falling edge; the transfer lands on the next rising edge
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Hold off the sender until every expected result has been taken
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          push_pct;
    int          run_left;
    logic [1:0]  op;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: underflow on an empty deque from both ends
    send_request(FUNC_POP_FRONT, 32'sd0);
    send_request(FUNC_POP_REAR, 32'sh7fffffff);
    // Extremes through both ends
    send_request(FUNC_PUSH_REAR, 32'sh7fffffff);
    send_request(FUNC_PUSH_FRONT, 32'sh80000000);
    send_request(FUNC_POP_FRONT, 32'sd0);
    send_request(FUNC_POP_REAR, 32'sd0);
    // Fill to full from alternating ends
    send_request(FUNC_PUSH_REAR, 32'sd0);
    send_request(FUNC_PUSH_FRONT, -32'sd1);
    send_request(FUNC_PUSH_REAR, 32'sh55555555);
    send_request(FUNC_PUSH_FRONT, 32'shaaaaaaaa);
    send_request(FUNC_PUSH_REAR, 32'sd1);
    send_request(FUNC_PUSH_FRONT, 32'sh80000000);
    send_request(FUNC_PUSH_REAR, 32'sh7fffffff);
    send_request(FUNC_PUSH_FRONT, 32'sh12345678);
    // Overflow at both ends
    send_request(FUNC_PUSH_REAR, 32'sh0badf00d);
    send_request(FUNC_PUSH_FRONT, -32'sd2);
    // Empty it from alternating ends, then underflow once more
    send_request(FUNC_POP_FRONT, 32'sd0);
    send_request(FUNC_POP_REAR, 32'sd0);
    send_request(FUNC_POP_FRONT, 32'sd0);
    send_request(FUNC_POP_REAR, 32'sd0);
    send_request(FUNC_POP_FRONT, 32'sd0);
    send_request(FUNC_POP_REAR, 32'sd0);
    send_request(FUNC_POP_FRONT, 32'sd0);
    send_request(FUNC_POP_REAR, 32'sd0);
    send_request(FUNC_POP_FRONT, -32'sd1);

    hold_until_drained();

    // Random: runs biased towards pushes, pops or neither, so full and empty both recur
    run_left = 0;
    push_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 300 && n < 700);
      if (n % 400 == 399)
        hold_until_drained();
      if (run_left == 0) begin
        run_left = $urandom_range(5, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
      else
        op = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_REAR;
      send_request(op, pick_value());
    end
    calm = 1'b0;

    // Drain, let the pipeline settle, then the verdict
    hold_until_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS circular_deque_core");
    else
      $display("FAIL circular_deque_core");
    $finish;
  end

endmodule
